[rtl/b64d_pkg.sv]
// b64d_pkg: shared types, constants and the character decode function
// for the Base64 stream decoder. No dependencies.

package b64d_pkg;

  // Default counter width and work queue depth
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Widths fixed by the word formats
  localparam int CHAR_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int CAP_W   = 16;
  localparam int CNT_W   = 16;
  localparam int SEXT_W  = 6;
  localparam int TRIPLE_W = 24;

  // Alphabet offsets
  localparam logic [SEXT_W-1:0] LOWER_BASE = 6'd26;
  localparam logic [SEXT_W-1:0] DIGIT_BASE = 6'd52;
  localparam logic [SEXT_W-1:0] PLUS_VAL   = 6'd62;
  localparam logic [SEXT_W-1:0] SLASH_VAL  = 6'd63;

  // Stream status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARSE = 2'd1,
    ST_NOBUF = 2'd2
  } err_t;

  // One decoded character
  typedef struct packed {
    logic              ok;
    logic [SEXT_W-1:0] val;
  } sextet_t;

  // One queued job: up to three data bytes and an optional summary
  typedef struct packed {
    logic [TRIPLE_W-1:0] triple;
    logic [2:0]          byte_en;
    logic                summ;
    err_t                status;
    logic [CNT_W-1:0]    count;
  } b64d_job_t;

  // Map one ASCII character to its 6-bit value
  function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] ch);
    sextet_t r;
    logic [CHAR_W-1:0] d;
    r = '0;
    d = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = ch - 8'h41;
      r.ok = 1'b1;
      r.val = d[SEXT_W-1:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = ch - 8'h61;
      r.ok = 1'b1;
      r.val = d[SEXT_W-1:0] + LOWER_BASE;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
      r.ok = 1'b1;
      r.val = d[SEXT_W-1:0] + DIGIT_BASE;
    end else if (ch == 8'h2B) begin
      r.ok = 1'b1;
      r.val = PLUS_VAL;
    end else if (ch == 8'h2F) begin
      r.ok = 1'b1;
      r.val = SLASH_VAL;
    end
    return r;
  endfunction

endpackage

[rtl/b64d_front.sv]
// b64d_front: accepts characters, tracks group and stream state, queues
// a job word per character that gives bytes or is last. Uses b64d_pkg.

module b64d_front #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [b64d_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                         acc,
  input  logic [b64d_pkg::CHAR_W-1:0]  enc_char,
  input  logic                         last_char,
  output logic                         push,
  output b64d_pkg::b64d_job_t          job
);

  localparam logic [31:0] CNT_MAX32 = 32'((64'(1) << COUNT_WIDTH) - 64'(1));

  // Capacity clipped to what the counter can hold
  function automatic logic [COUNT_WIDTH-1:0] clip_cap(input logic [b64d_pkg::CAP_W-1:0] c);
    logic [31:0] c32;
    c32 = 32'(c);
    if (c32 > CNT_MAX32) c32 = CNT_MAX32;
    return c32[COUNT_WIDTH-1:0];
  endfunction

  logic [COUNT_WIDTH-1:0] cap_r;
  logic [1:0]             pos_r, pos_nxt;
  logic [17:0]            sext_r, sext_nxt;
  logic                   tv_r, tv_nxt;
  logic [COUNT_WIDTH-1:0] bw_r, bw_nxt;
  b64d_pkg::err_t         err_r, err_nxt;

  b64d_pkg::sextet_t      dec;
  logic                   fin, dval;
  logic [COUNT_WIDTH-1:0] avail;
  logic [2:0]             en;
  logic [31:0]            bw32;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= clip_cap({b64d_pkg::CAP_W{1'b1}});
    end else if (cfg_wr_en) begin
      cap_r <= clip_cap(cfg_wr_data);
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sext_r <= '0;
      tv_r   <= 1'b0;
      bw_r   <= '0;
      err_r  <= b64d_pkg::ST_OK;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      sext_r <= sext_nxt;
      tv_r   <= tv_nxt;
      bw_r   <= bw_nxt;
      err_r  <= err_nxt;
    end
  end

  assign dec   = b64d_pkg::sextet_of(enc_char);
  assign avail = cap_r - bw_r;

  // Next state and job word
  always_comb begin
    pos_nxt  = pos_r;
    sext_nxt = sext_r;
    tv_nxt   = tv_r;
    bw_nxt   = bw_r;
    err_nxt  = err_r;
    fin      = 1'b0;
    dval     = 1'b0;
    en       = '0;
    bw32     = '0;
    job      = '0;

    if (err_r == b64d_pkg::ST_OK) begin
      // Place this character in the group
      unique case (pos_r)
        2'd0: begin
          if (!dec.ok) begin
            err_nxt = b64d_pkg::ST_PARSE;
          end else begin
            sext_nxt = {dec.val, 12'b0};
            tv_nxt   = 1'b0;
            pos_nxt  = 2'd1;
          end
        end
        2'd1: begin
          if (!dec.ok) begin
            err_nxt = b64d_pkg::ST_PARSE;
          end else begin
            sext_nxt[11:6] = dec.val;
            pos_nxt        = 2'd2;
          end
        end
        2'd2: begin
          tv_nxt  = dec.ok;
          if (dec.ok) sext_nxt[5:0] = dec.val;
          pos_nxt = 2'd3;
        end
        default: begin
          fin  = 1'b1;
          dval = dec.ok;
        end
      endcase

      // A final character closes a short group
      if (last_char && err_nxt == b64d_pkg::ST_OK && pos_nxt != 2'd0 && pos_r != 2'd3) begin
        fin = 1'b1;
      end

      // Finish the group: room check on each byte
      if (fin) begin
        job.triple = {sext_nxt, (dval ? dec.val : 6'd0)};
        if (bw_r >= cap_r) begin
          err_nxt = b64d_pkg::ST_NOBUF;
        end else begin
          en[0] = 1'b1;
          en[1] = tv_nxt && (avail >= COUNT_WIDTH'(2));
          en[2] = dval && (en[1] ? (avail >= COUNT_WIDTH'(3)) : (avail >= COUNT_WIDTH'(2)));
        end
        bw_nxt   = bw_r + COUNT_WIDTH'(en[0]) + COUNT_WIDTH'(en[1]) + COUNT_WIDTH'(en[2]);
        pos_nxt  = 2'd0;
        sext_nxt = '0;
        tv_nxt   = 1'b0;
      end
    end

    job.byte_en = en;

    // Summary closes the stream and clears it
    if (last_char) begin
      bw32       = 32'(bw_nxt);
      job.summ   = 1'b1;
      job.status = err_nxt;
      job.count  = bw32[b64d_pkg::CNT_W-1:0];
      pos_nxt    = 2'd0;
      sext_nxt   = '0;
      tv_nxt     = 1'b0;
      bw_nxt     = '0;
      err_nxt    = b64d_pkg::ST_OK;
    end
  end

  assign push = acc && ((|en) || last_char);

  // A closed stream restarts from a clean state
  a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_char) |=> (pos_r == 2'd0 && bw_r == '0 && err_r == b64d_pkg::ST_OK))
    else $error("stream state not cleared after final character");

  // Bytes never exceed the capacity in force when no config write intervenes
  a_cap_respected: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_wr_en && bw_r <= cap_r) |=> (bw_r <= cap_r))
    else $error("byte count went past capacity");

endmodule

[rtl/b64d_queue.sv]
// b64d_queue: short register queue of job words between front and back.
// Uses b64d_pkg for the job word type.

module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64d_pkg::b64d_job_t wr_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output b64d_pkg::b64d_job_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64d_pkg::b64d_job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

[rtl/b64d_back.sv]
// b64d_back: expands each job word into result words, one per cycle while
// out_ready is high, through an output register. Uses b64d_pkg.

module b64d_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  b64d_pkg::b64d_job_t          q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b64d_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_is_summary,
  output logic [1:0]                   out_status,
  output logic [b64d_pkg::CNT_W-1:0]   out_written_count,
  output logic                         out_run_last
);

  b64d_pkg::b64d_job_t job_r;
  logic                job_vld_r;
  logic [3:0]          rem_r;

  logic                        out_valid_r;
  logic [b64d_pkg::BYTE_W-1:0] byte_r;
  logic                        summ_r;
  logic [1:0]                  status_r;
  logic [b64d_pkg::CNT_W-1:0]  count_r;
  logic                        last_r;

  logic [3:0]                  sel;
  logic [3:0]                  rem_after;
  logic                        out_load, done;
  logic [b64d_pkg::BYTE_W-1:0] byte_sel;

  // Pick the lowest pending result of the job
  always_comb begin
    sel      = '0;
    byte_sel = '0;
    if (rem_r[0]) begin
      sel[0]   = 1'b1;
      byte_sel = job_r.triple[23:16];
    end else if (rem_r[1]) begin
      sel[1]   = 1'b1;
      byte_sel = job_r.triple[15:8];
    end else if (rem_r[2]) begin
      sel[2]   = 1'b1;
      byte_sel = job_r.triple[7:0];
    end else begin
      sel[3]   = 1'b1;
    end
  end

  assign rem_after = rem_r & ~sel;
  assign out_load  = job_vld_r && (!out_valid_r || out_ready);
  assign done      = out_load && (rem_after == '0);
  assign q_pop     = q_not_empty && (!job_vld_r || done);

  // Current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      rem_r     <= '0;
    end else if (q_pop) begin
      job_vld_r <= 1'b1;
      rem_r     <= {q_data.summ, q_data.byte_en};
    end else if (done) begin
      job_vld_r <= 1'b0;
      rem_r     <= '0;
    end else if (out_load) begin
      rem_r     <= rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      byte_r   <= byte_sel;
      summ_r   <= sel[3];
      status_r <= sel[3] ? job_r.status : 2'd0;
      count_r  <= sel[3] ? job_r.count : '0;
      last_r   <= (rem_after == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_is_summary    = summ_r;
  assign out_status        = status_r;
  assign out_written_count = count_r;
  assign out_run_last      = last_r;

  a_job_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r |-> (rem_r != '0))
    else $error("active job with nothing left to send");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && summ_r) |-> last_r)
    else $error("summary word not marked as last");

endmodule

[rtl/base64_stream_decoder.sv]
// base64_stream_decoder: top level of the Base64 stream decoder.
// Instantiates b64d_front, b64d_queue and b64d_back; uses b64d_pkg.

// Takes one Base64 character per cycle while in_ready is high and gives
// decoded bytes, then one summary word (status and byte count) for the
// character marked last_char; out_run_last flags the final word caused by
// each character. The front end decodes a character in the cycle it is
// accepted and writes at most one job word into a QUEUE_DEPTH-entry queue;
// in_ready is low only while that queue is full. The back end sends one
// result word per cycle from each job while out_ready is high: plain text
// (three bytes per four characters) runs at one character per cycle, while
// streams that close very short groups are paced by the back end at one
// result word per cycle. The first result word of a character passes
// through the queue, then the job register, then the output register,
// before it is offered on out_valid. The capacity set by cfg_wr_data is
// clipped to what COUNT_WIDTH bits can count.

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [b64d_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b64d_pkg::CHAR_W-1:0]  in_enc_char,
  input  logic                         in_last_char,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b64d_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_is_summary,
  output logic [1:0]                   out_status,
  output logic [b64d_pkg::CNT_W-1:0]   out_written_count,
  output logic                         out_run_last
);

  logic                q_full, q_not_empty, q_push, q_pop, acc;
  b64d_pkg::b64d_job_t push_job, pop_job;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  b64d_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .enc_char    (in_enc_char),
    .last_char   (in_last_char),
    .push        (q_push),
    .job         (push_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_data   (pop_job)
  );

  b64d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_data            (pop_job),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_is_summary    (out_is_summary),
    .out_status        (out_status),
    .out_written_count (out_written_count),
    .out_run_last      (out_run_last)
  );

endmodule
